>>> hdl/sdt_pkg.sv
// Shared types, constants and microcode for the scaled-dimension text printer.
package sdt_pkg;

    localparam int VALUE_W = 31;
    localparam int IP_W    = 15;   // integer part of a magnitude up to 2^30
    localparam int F_W     = 20;   // fraction accumulator, below 655360
    localparam int PC_W    = 4;

    localparam logic [F_W-1:0] HALF_UNIT   = 20'h08000;
    localparam logic [F_W-1:0] ROUND_SHIFT = 20'd50000;

    localparam logic [6:0] CH_MINUS = 7'h2d;
    localparam logic [6:0] CH_DOT   = 7'h2e;
    localparam logic [6:0] CH_ZERO  = 7'h30;

    typedef enum logic [2:0] {
        OP_SIGN,
        OP_INT,
        OP_DOT,
        OP_FRAC,
        OP_SUF
    } op_t;

    typedef struct packed {
        op_t             op;
        logic [2:0]      arg;   // power index or suffix position
        logic [PC_W-1:0] jmp;   // loop target of the fraction step
    } ucode_t;

    // Control program: sign, five integer digits, point, fraction loop, suffix.
    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        w = '{op: OP_SUF, arg: 3'd4, jmp: 4'd0};
        case (pc)
            4'd0:    w = '{op: OP_SIGN, arg: 3'd0, jmp: 4'd0};
            4'd1:    w = '{op: OP_INT,  arg: 3'd0, jmp: 4'd0};
            4'd2:    w = '{op: OP_INT,  arg: 3'd1, jmp: 4'd0};
            4'd3:    w = '{op: OP_INT,  arg: 3'd2, jmp: 4'd0};
            4'd4:    w = '{op: OP_INT,  arg: 3'd3, jmp: 4'd0};
            4'd5:    w = '{op: OP_INT,  arg: 3'd4, jmp: 4'd0};
            4'd6:    w = '{op: OP_DOT,  arg: 3'd0, jmp: 4'd0};
            4'd7:    w = '{op: OP_FRAC, arg: 3'd0, jmp: 4'd7};
            4'd8:    w = '{op: OP_SUF,  arg: 3'd0, jmp: 4'd0};
            4'd9:    w = '{op: OP_SUF,  arg: 3'd1, jmp: 4'd0};
            4'd10:   w = '{op: OP_SUF,  arg: 3'd2, jmp: 4'd0};
            4'd11:   w = '{op: OP_SUF,  arg: 3'd3, jmp: 4'd0};
            4'd12:   w = '{op: OP_SUF,  arg: 3'd4, jmp: 4'd0};
            default: w = '{op: OP_SUF,  arg: 3'd4, jmp: 4'd0};
        endcase
        return w;
    endfunction

    function automatic logic [IP_W-1:0] pow10(input logic [2:0] idx);
        logic [IP_W-1:0] p;
        case (idx)
            3'd0:    p = 15'd10000;
            3'd1:    p = 15'd1000;
            3'd2:    p = 15'd100;
            3'd3:    p = 15'd10;
            default: p = 15'd1;
        endcase
        return p;
    endfunction

    // Rounding window after fraction digit k.
    function automatic logic [F_W-1:0] frac_delta(input logic [2:0] k);
        logic [F_W-1:0] d;
        case (k)
            3'd0:    d = 20'd100;
            3'd1:    d = 20'd1000;
            3'd2:    d = 20'd10000;
            3'd3:    d = 20'd100000;
            default: d = 20'd1000000;
        endcase
        return d;
    endfunction

    function automatic logic [2:0] suf_len(input logic [1:0] order);
        logic [2:0] n;
        case (order)
            2'd0:    n = 3'd2;
            2'd1:    n = 3'd3;
            2'd2:    n = 3'd4;
            default: n = 3'd5;
        endcase
        return n;
    endfunction

    function automatic logic [6:0] suf_char(input logic [1:0] order, input logic mu,
                                            input logic [2:0] pos);
        logic [6:0] c;
        c = 7'h6c;  // 'l'
        if (order == 2'd0) begin
            if (mu)
                c = (pos == 3'd0) ? 7'h6d : 7'h75;   // "mu"
            else
                c = (pos == 3'd0) ? 7'h70 : 7'h74;   // "pt"
        end
        else begin
            case (pos)
                3'd0:    c = 7'h66;   // 'f'
                3'd1:    c = 7'h69;   // 'i'
                default: c = 7'h6c;   // 'l'
            endcase
        end
        return c;
    endfunction

endpackage

>>> hdl/scaled_dimension_to_text.sv
// Scaled-dimension printer: signed 15.16 length to ASCII text with unit suffix.
//
// Pulse start while busy is low to hand in a request (value, order, math_units).
// The characters then leave on char_code, each flagged by a one-cycle strobe,
// with last_char on the final one; the receiver must take every strobe.
// A small control program stepped by a program counter runs one step per cycle:
// sign, five integer-digit steps (leading zeros are skipped but still take their
// step), the point, one step per fraction digit (1 to 5) and one per suffix
// character (2 to 5). Busy falls as the last character is registered, and a new
// request can be taken on the cycle that carries the last character.
module scaled_dimension_to_text
    import sdt_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [VALUE_W-1:0] value,
    input  logic        [1:0]         order,
    input  logic                      math_units,
    output logic                      strobe,
    output logic        [6:0]         char_code,
    output logic                      last_char
);

    logic            busy_reg, busy_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    logic            neg_reg, neg_next;
    logic [IP_W-1:0] ip_reg, ip_next;
    logic [F_W-1:0]  f_reg, f_next;
    logic [2:0]      k_reg, k_next;
    logic            started_reg, started_next;
    logic [1:0]      order_reg, order_next;
    logic            mu_reg, mu_next;
    logic            strobe_reg, strobe_next;
    logic [6:0]      char_reg, char_next;
    logic            last_reg, last_next;

    ucode_t              uw;
    logic [VALUE_W-1:0]  mag;
    logic [F_W-1:0]      frac10;
    logic [IP_W+1:0]     mult [10];
    logic [3:0]          idig;
    logic [IP_W-1:0]     pw;
    logic [F_W-1:0]      fa;
    logic [F_W-1:0]      fnew;

    assign uw = ucode_rom(pc_reg);

    // magnitude of the incoming request
    assign mag    = value[VALUE_W-1] ? (~value + 31'd1) : value;
    assign frac10 = {1'b0, mag[15:0], 3'b000} + {3'b000, mag[15:0], 1'b0} + 20'd5;

    // integer digit at the current power: largest d with d*p <= ip
    assign pw = pow10(uw.arg);
    always_comb
    begin
        idig = 4'd0;
        for (int d = 0; d < 10; d++) begin
            mult[d] = 17'(d) * {2'b00, pw};
        end
        for (int d = 1; d < 10; d++) begin
            if ({2'b00, ip_reg} >= mult[d])
                idig = 4'(d);
        end
    end

    // fraction step; rounding shift applies on the fifth digit only
    assign fa   = (k_reg == 3'd4) ? (f_reg + HALF_UNIT - ROUND_SHIFT) : f_reg;
    assign fnew = {1'b0, fa[15:0], 3'b000} + {3'b000, fa[15:0], 1'b0};

    always_comb
    begin
        busy_next    = busy_reg;
        pc_next      = pc_reg;
        neg_next     = neg_reg;
        ip_next      = ip_reg;
        f_next       = f_reg;
        k_next       = k_reg;
        started_next = started_reg;
        order_next   = order_reg;
        mu_next      = mu_reg;
        strobe_next  = 1'b0;
        char_next    = char_reg;
        last_next    = 1'b0;

        if (!busy_reg) begin
            if (start) begin
                busy_next    = 1'b1;
                pc_next      = '0;
                neg_next     = value[VALUE_W-1];
                ip_next      = mag[VALUE_W-1:16];
                f_next       = frac10;
                k_next       = '0;
                started_next = 1'b0;
                order_next   = order;
                mu_next      = math_units;
            end
        end
        else begin
            pc_next = pc_reg + 4'd1;
            case (uw.op)
                OP_SIGN:
                begin
                    strobe_next = neg_reg;
                    char_next   = CH_MINUS;
                end
                OP_INT:
                begin
                    ip_next = ip_reg - mult[idig][IP_W-1:0];
                    if (idig != 4'd0 || started_reg || uw.arg == 3'd4) begin
                        strobe_next  = 1'b1;
                        started_next = 1'b1;
                    end
                    char_next = CH_ZERO + {3'b000, idig};
                end
                OP_DOT:
                begin
                    strobe_next = 1'b1;
                    char_next   = CH_DOT;
                end
                OP_FRAC:
                begin
                    strobe_next = 1'b1;
                    char_next   = CH_ZERO + {3'b000, fa[19:16]};
                    f_next      = fnew;
                    k_next      = k_reg + 3'd1;
                    if (fnew > frac_delta(k_reg))
                        pc_next = uw.jmp;
                end
                OP_SUF:
                begin
                    strobe_next = 1'b1;
                    char_next   = suf_char(order_reg, mu_reg, uw.arg);
                    if (uw.arg == suf_len(order_reg) - 3'd1) begin
                        last_next = 1'b1;
                        busy_next = 1'b0;
                    end
                end
                default:
                begin
                    busy_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg   <= 1'b0;
            pc_reg     <= '0;
            strobe_reg <= 1'b0;
            last_reg   <= 1'b0;
        end
        else begin
            busy_reg   <= busy_next;
            pc_reg     <= pc_next;
            strobe_reg <= strobe_next;
            last_reg   <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg     <= neg_next;
        ip_reg      <= ip_next;
        f_reg       <= f_next;
        k_reg       <= k_next;
        started_reg <= started_next;
        order_reg   <= order_next;
        mu_reg      <= mu_next;
        char_reg    <= char_next;
    end

    assign busy      = busy_reg;
    assign strobe    = strobe_reg;
    assign char_code = char_reg;
    assign last_char = last_reg;

endmodule

>>> bench/scaled_dimension_to_text_test.sv
// Self-checking bench for the scaled-dimension text printer: random and edge-case requests.
module scaled_dimension_to_text_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sdt_pkg::*;

    localparam int CLK_HALF    = 4;
    localparam int RANDOM_REQS = 150;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 40;

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        logic        [1:0]         order;
        logic                      math_units;
    } length_req_t;

    typedef struct {
        logic [6:0] code;
        logic       last;
    } text_char_t;

    logic                      clk        = 1'b0;
    logic                      rst_n      = 1'b0;
    logic                      start      = 1'b0;
    logic signed [VALUE_W-1:0] value      = '0;
    logic        [1:0]         order      = '0;
    logic                      math_units = 1'b0;
    logic                      busy;
    logic                      strobe;
    logic        [6:0]         char_code;
    logic                      last_char;

    length_req_t pending_reqs[$];
    text_char_t  expected_text[$];
    int          mismatches = 0;
    int          cycles     = 0;
    int          idle_left  = 0;
    int          burst_left = 0;

    scaled_dimension_to_text i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .value      (value),
        .order      (order),
        .math_units (math_units),
        .strobe     (strobe),
        .char_code  (char_code),
        .last_char  (last_char)
    );

    always #CLK_HALF clk = ~clk;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at cycle %0d: %s got 0x%0h expected 0x%0h", cycles, what, got, want);
        mismatches++;
    endtask

    task automatic add_request(input logic signed [VALUE_W-1:0] v, input logic [1:0] ord,
                               input logic mu);
        length_req_t r;
        r.value      = v;
        r.order      = ord;
        r.math_units = mu;
        pending_reqs.push_back(r);
    endtask

    // Expected characters of one length, in print_scaled style.
    function automatic void render_length(input logic [VALUE_W-1:0] raw,
                                          input logic [1:0] ord, input logic mu);
        logic [VALUE_W-1:0] mag;
        int unsigned        whole;
        int unsigned        f;
        int unsigned        delta;
        logic [6:0]         text[$];
        logic [6:0]         digs[$];
        string              suffix;
        text_char_t         c;
        mag = raw;
        if (raw[VALUE_W-1])
        begin
            mag = ~raw + 1'b1;
            text.push_back(CH_MINUS);
        end
        whole = int'(mag >> 16);
        do
        begin
            digs.push_front(CH_ZERO + 7'(whole % 10));
            whole = whole / 10;
        end
        while (whole != 0);
        foreach (digs[i])
            text.push_back(digs[i]);
        text.push_back(CH_DOT);
        f     = 10 * int'(mag[15:0]) + 5;
        delta = 10;
        do
        begin
            if (delta > 32'h10000)
                f = f + 32'h8000 - 50000;
            text.push_back(CH_ZERO + 7'(f >> 16));
            f     = 10 * (f & 32'hffff);
            delta = delta * 10;
        end
        while (f > delta);
        case (ord)
            2'd0:    suffix = mu ? "mu" : "pt";
            2'd1:    suffix = "fil";
            2'd2:    suffix = "fill";
            default: suffix = "filll";
        endcase
        for (int i = 0; i < suffix.len(); i++)
            text.push_back(7'(suffix[i]));
        foreach (text[i])
        begin
            c.code = text[i];
            c.last = (i == text.size() - 1);
            expected_text.push_back(c);
        end
    endfunction

    function automatic int pick_idle();
        int r;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5)
            burst_left = $urandom_range(5, 15);
        if (r < 40)
            return 0;
        else if (r < 80)
            return $urandom_range(1, 24);
        else if (r < 95)
            return $urandom_range(25, 40);
        else
            return $urandom_range(60, 150);
    endfunction

    // Request driver
    always @(posedge clk)
    begin : drive
        length_req_t nxt;
        if (!rst_n)
            start <= 1'b0;
        else
        begin
            if (start && !busy)
            begin
                render_length(value, order, math_units);
                idle_left = pick_idle();
            end
            if (!start || !busy)
            begin
                if (idle_left > 0)
                begin
                    idle_left--;
                    start <= 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    nxt = pending_reqs.pop_front();
                    start      <= 1'b1;
                    value      <= nxt.value;
                    order      <= nxt.order;
                    math_units <= nxt.math_units;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Character monitor
    always @(posedge clk)
    begin : watch
        text_char_t want;
        if (rst_n && strobe)
        begin
            if (expected_text.size() == 0)
                report_mismatch("unexpected character", int'(char_code), 0);
            else
            begin
                want = expected_text.pop_front();
                if (char_code !== want.code)
                    report_mismatch("char_code", int'(char_code), int'(want.code));
                if (last_char !== want.last)
                    report_mismatch("last_char", int'(last_char), int'(want.last));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [VALUE_W-1:0] m;
        logic signed [VALUE_W-1:0] v;

        add_request(31'sd0, 2'd0, 1'b0);
        add_request(31'sd0, 2'd0, 1'b1);
        add_request(31'sd1, 2'd1, 1'b0);
        add_request(-31'sd1, 2'd2, 1'b1);
        add_request(31'sd65536, 2'd3, 1'b1);
        add_request(-31'sd65536, 2'd0, 1'b1);
        add_request(31'sd32768, 2'd0, 1'b0);
        add_request(31'sd65535, 2'd1, 1'b1);
        add_request(31'sd1073741823, 2'd0, 1'b0);
        add_request(-31'sd1073741823, 2'd1, 1'b1);
        // most negative code: outside the stated range but still printable
        add_request(31'h40000000, 2'd2, 1'b0);
        add_request(31'h40000000, 2'd0, 1'b1);
        add_request(31'sd661914, 2'd3, 1'b0);
        add_request(31'sd809041921, 2'd2, 1'b1);
        add_request(31'sd655, 2'd0, 1'b0);
        add_request(31'sd6553, 2'd3, 1'b1);
        add_request(31'sd6554, 2'd1, 1'b0);
        add_request(-31'sd13107, 2'd0, 1'b1);
        add_request(31'sd655360000, 2'd2, 1'b0);
        add_request(-31'sd1048575, 2'd3, 1'b0);

        for (int n = 0; n < RANDOM_REQS; n++)
        begin
            case ($urandom_range(0, 3))
                0:       m = VALUE_W'($urandom);
                1:       m = VALUE_W'($urandom_range(0, 65535));
                2:       m = VALUE_W'(($urandom_range(0, 999) << 16) | $urandom_range(0, 65535));
                default: m = VALUE_W'($urandom_range(0, 1073741823));
            endcase
            v = $urandom_range(0, 1) ? -m : m;
            add_request(v, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || start || expected_text.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
